// ===== rtl/bcpd_pkg.sv =====
// Shared types and constants of the button click pattern detector.
// Used by every module under rtl/; depends on nothing.
`default_nettype none

package bcpd_pkg;

   // Width of the internal millisecond timestamps; differences wrap modulo 2^TIME_WIDTH.
   localparam int TIME_WIDTH = 32;

   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 40;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Bit positions in event_flags.
   localparam int EV_PRESS  = 0;
   localparam int EV_CLICK  = 1;
   localparam int EV_DOUBLE = 2;
   localparam int EV_MULTI  = 3;
   localparam int EV_LSTART = 4;
   localparam int EV_LSTOP  = 5;
   localparam int EV_DURING = 6;
   localparam int EV_IDLE   = 7;

   localparam logic [7:0] COUNT_MAX     = 8'd255;
   localparam logic [7:0] COUNT_SINGLE  = 8'd1;
   localparam logic [7:0] COUNT_DOUBLE  = 8'd2;

   typedef logic [TIME_WIDTH-1:0] stamp_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE   = 3'd0,
      CSR_CLICK_GAP  = 3'd1,
      CSR_LONG_PRESS = 3'd2,
      CSR_IDLE_TIME  = 3'd3,
      CSR_REPEAT     = 3'd4,
      CSR_ACTIVE_LOW = 3'd5,
      CSR_CLICK_LIM  = 3'd6,
      CSR_EVENT_EN   = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_DOWN  = 3'd1,
      ST_UP    = 3'd2,
      ST_COUNT = 3'd3,
      ST_LONG  = 3'd4,
      ST_END   = 3'd5
   } fsm_state_type;

   typedef struct packed {
      logic signed [15:0] debounce_time;
      logic [15:0]        click_gap_time;
      logic [15:0]        long_press_time;
      logic [15:0]        idle_time;
      logic [15:0]        repeat_interval;
      logic               active_low;
      logic [7:0]         click_limit;
      logic [7:0]         event_enable;
   } cfg_type;

   // One classified word handed from the front end to the state machine.
   typedef struct packed {
      logic      soft_reset;
      logic      clean;
      stamp_type now;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic stamp_type to_stamp(input logic [31:0] t);
      return stamp_type'(t);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/bcpd_front.sv =====
// Front end: polarity and debounce of the raw pin level for each accepted word.
// Depends on bcpd_pkg.
`default_nettype none

module bcpd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bcpd_pkg::cfg_type cfg,
   input  wire logic              accept,
   input  wire logic              action,
   input  wire logic              pin_level,
   input  wire logic [31:0]       time_now,
   output bcpd_pkg::item_type     item
);
   import bcpd_pkg::*;

   logic      last_raw_ff, last_raw_in;
   logic      clean_ff, clean_in;
   stamp_type change_ff, change_in;

   stamp_type   now;
   stamp_type   elapsed;
   logic        act;
   logic [15:0] need;

   assign now     = to_stamp(time_now);
   assign act     = pin_level ^ cfg.active_low;
   assign elapsed = now - change_ff;
   assign need    = cfg.debounce_time[15] ? 16'(-cfg.debounce_time) : cfg.debounce_time;

   always_comb begin
      last_raw_in = last_raw_ff;
      clean_in    = clean_ff;
      change_in   = change_ff;
      if (accept && !action) begin
         // A negative stable time lets a press through at once.
         if (act && cfg.debounce_time[15]) begin
            clean_in = 1'b1;
         end
         if (last_raw_ff == act) begin
            if (elapsed >= stamp_type'(need)) begin
               clean_in = act;
            end
         end else begin
            change_in   = now;
            last_raw_in = act;
         end
      end
   end

   assign item.soft_reset = action;
   assign item.clean      = clean_in;
   assign item.now        = now;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff <= 1'b0;
         clean_ff    <= 1'b0;
         change_ff   <= '0;
      end else begin
         last_raw_ff <= last_raw_in;
         clean_ff    <= clean_in;
         change_ff   <= change_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bcpd_queue.sv =====
// Short queue that decouples the debounce front end from the state machine.
// Depends on bcpd_pkg.
`default_nettype none

module bcpd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire bcpd_pkg::item_type push_item,
   input  wire logic               pop,
   output bcpd_pkg::item_type      pop_item,
   output bcpd_pkg::queue_status_type status
);
   import bcpd_pkg::*;

   item_type entry_ff [QUEUE_DEPTH];

   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   assign pop_item     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bcpd_back.sv =====
// Back end: click and long-press state machine plus the result register.
// Depends on bcpd_pkg.
`default_nettype none

module bcpd_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bcpd_pkg::cfg_type             cfg,
   input  wire bcpd_pkg::item_type            item,
   input  wire logic                          item_valid,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [bcpd_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import bcpd_pkg::*;

   fsm_state_type state_ff, state_in;
   logic          idle_rep_ff, idle_rep_in;
   logic [7:0]    count_ff, count_in;
   stamp_type     start_ff, start_in;
   stamp_type     repeat_ff, repeat_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   stamp_type  wait_time;
   stamp_type  since_repeat;
   logic [7:0] ev;
   logic [15:0] held;
   logic       gap_done;

   assign pop          = item_valid && (!rsp_valid_ff || rsp_tready);
   assign wait_time    = item.now - start_ff;
   assign since_repeat = item.now - repeat_ff;
   assign gap_done     = (wait_time >= stamp_type'(cfg.click_gap_time)) ||
                         (count_ff == cfg.click_limit);

   // Next state.
   always_comb begin
      state_in = state_ff;
      if (pop) begin
         if (item.soft_reset) begin
            state_in = ST_IDLE;
         end else begin
            case (state_ff)
               ST_IDLE: begin
                  if (item.clean) state_in = ST_DOWN;
               end
               ST_DOWN: begin
                  if (!item.clean) begin
                     state_in = ST_UP;
                  end else if (wait_time > stamp_type'(cfg.long_press_time)) begin
                     state_in = ST_LONG;
                  end
               end
               ST_UP: state_in = ST_COUNT;
               ST_COUNT: begin
                  if (item.clean) begin
                     state_in = ST_DOWN;
                  end else if (gap_done) begin
                     state_in = ST_IDLE;
                  end
               end
               ST_LONG: begin
                  if (!item.clean) state_in = ST_END;
               end
               ST_END: state_in = ST_IDLE;
               default: state_in = ST_IDLE;
            endcase
         end
      end
   end

   // Events, counters and timestamps.
   always_comb begin
      ev          = '0;
      idle_rep_in = idle_rep_ff;
      count_in    = count_ff;
      start_in    = start_ff;
      repeat_in   = repeat_ff;
      if (pop) begin
         if (item.soft_reset) begin
            idle_rep_in = 1'b0;
            count_in    = '0;
            start_in    = item.now;
         end else begin
            case (state_ff)
               ST_IDLE: begin
                  // The idle flag only latches when the idle event is enabled.
                  if (!idle_rep_ff && (wait_time > stamp_type'(cfg.idle_time)) &&
                      cfg.event_enable[EV_IDLE]) begin
                     idle_rep_in = 1'b1;
                     ev[EV_IDLE] = 1'b1;
                  end
                  if (item.clean) begin
                     start_in     = item.now;
                     count_in     = '0;
                     ev[EV_PRESS] = 1'b1;
                  end
               end
               ST_DOWN: begin
                  if (!item.clean) begin
                     start_in = item.now;
                  end else if (wait_time > stamp_type'(cfg.long_press_time)) begin
                     ev[EV_LSTART] = 1'b1;
                  end
               end
               ST_UP: begin
                  if (count_ff < COUNT_MAX) count_in = count_ff + 8'd1;
               end
               ST_COUNT: begin
                  if (item.clean) begin
                     start_in = item.now;
                  end else if (gap_done) begin
                     if (count_ff == COUNT_SINGLE) begin
                        ev[EV_CLICK] = 1'b1;
                     end else if (count_ff == COUNT_DOUBLE) begin
                        ev[EV_DOUBLE] = 1'b1;
                     end else begin
                        ev[EV_MULTI] = 1'b1;
                     end
                     idle_rep_in = 1'b0;
                     count_in    = '0;
                     start_in    = item.now;
                  end
               end
               ST_LONG: begin
                  if (item.clean && (since_repeat >= stamp_type'(cfg.repeat_interval))) begin
                     ev[EV_DURING] = 1'b1;
                     repeat_in     = item.now;
                  end
               end
               ST_END: begin
                  ev[EV_LSTOP] = 1'b1;
                  idle_rep_in  = 1'b0;
                  count_in     = '0;
                  start_in     = item.now;
               end
               default: ;
            endcase
         end
      end
   end

   assign held = 16'(item.now - start_in);

   always_comb begin
      rsp_data_in = {4'b0000, held, item.clean, 3'(state_in), count_in,
                     ev & cfg.event_enable};
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idle_rep_ff  <= 1'b0;
         count_ff     <= '0;
         start_ff     <= '0;
         repeat_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idle_rep_ff  <= idle_rep_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         repeat_ff    <= repeat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/button_click_pattern_detector.sv =====
// Button click pattern detector: one result word for each accepted word.
// A word is written into the queue, and its result is held in the result register until the output takes it.
// Throughput: one word per cycle while rsp_tready holds; the debounce stage and the state machine each take one.
// A two-entry queue between them and the result register decouple the two sides; a full queue holds off new words.
// Synchronous reset restores the default configuration and clears all state; no clearing pass.
// Depends on bcpd_pkg, bcpd_front, bcpd_queue and bcpd_back.
`default_nettype none

module button_click_pattern_detector (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [0] pin_level, [32:1] time_now, upper bits zero
   input  wire logic [bcpd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] action (0 sample, 1 soft reset)
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [7:0] event_flags, [15:8] click_total, [18:16] machine_state,
   // [19] clean_level, [35:20] held_time, upper bits zero
   output logic [bcpd_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [bcpd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bcpd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bcpd_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   item_type         front_item;
   item_type         queue_item;
   queue_status_type q_stat;
   logic             req_accept;
   logic             q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE:   cfg_in.debounce_time   = csr_wdata;
            CSR_CLICK_GAP:  cfg_in.click_gap_time  = csr_wdata;
            CSR_LONG_PRESS: cfg_in.long_press_time = csr_wdata;
            CSR_IDLE_TIME:  cfg_in.idle_time       = csr_wdata;
            CSR_REPEAT:     cfg_in.repeat_interval = csr_wdata;
            CSR_ACTIVE_LOW: cfg_in.active_low      = csr_wdata[0];
            CSR_CLICK_LIM:  cfg_in.click_limit     = csr_wdata[7:0];
            CSR_EVENT_EN:   cfg_in.event_enable    = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time   <= 16'sd50;
         cfg_ff.click_gap_time  <= 16'd400;
         cfg_ff.long_press_time <= 16'd800;
         cfg_ff.idle_time       <= 16'd1000;
         cfg_ff.repeat_interval <= 16'd0;
         cfg_ff.active_low      <= 1'b1;
         cfg_ff.click_limit     <= 8'd1;
         cfg_ff.event_enable    <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !q_stat.full;
   assign req_accept = req_tvalid && req_tready;

   bcpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .accept    (req_accept),
      .action    (req_tuser),
      .pin_level (req_tdata[0]),
      .time_now  (req_tdata[32:1]),
      .item      (front_item)
   );

   bcpd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_item (front_item),
      .pop       (q_pop),
      .pop_item  (queue_item),
      .status    (q_stat)
   );

   bcpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item       (queue_item),
      .item_valid (!q_stat.empty),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // The queue can never report full and empty together.
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue reports full and empty at once");

   // A word taken in always lands in the queue.
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !q_stat.empty)
      else $error("accepted word did not reach the queue");

   // Every path into idle clears the click count.
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[18:16] == 3'(ST_IDLE))) |-> (rsp_tdata[15:8] == 8'd0))
      else $error("idle result with nonzero click count");

   // Reported events are always a subset of the enabled ones.
   a_event_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[7:0] & ~cfg_ff.event_enable) == 8'd0))
      else $error("disabled event reported");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for button_click_pattern_detector: a directed table, then random
// button gestures under several register settings, each result word checked by a predictor or a table value.
// Depends on rtl/bcpd_pkg.sv and rtl/button_click_pattern_detector.sv.
module tb_top;
   import bcpd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 7;
   localparam int PHASE_WORDS = 84;

   // Result fields, lowest bits last, laid out as in rsp_tdata.
   typedef struct packed {
      logic [15:0] held;
      logic        clean;
      logic [2:0]  state;
      logic [7:0]  total;
      logic [7:0]  flags;
   } button_report_type;

   typedef enum logic {ROW_REG, ROW_WORD} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      csr_index_type     reg_idx;
      logic [15:0]       reg_val;
      logic              restart;
      logic              pin;
      logic [31:0]       stamp;
      logic              golden;
      button_report_type want;
   } plan_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_DEBOUNCE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   logic [31:0] now_ms = '0;

   button_report_type pending_reports[$];
   plan_row_type plan[$];

   // Predictor copy of the registers and of the detector state.
   cfg_type knob = '{debounce_time: 16'sd50, click_gap_time: 16'd400,
                     long_press_time: 16'd800, idle_time: 16'd1000,
                     repeat_interval: 16'd0, active_low: 1'b1,
                     click_limit: 8'd1, event_enable: 8'd0};
   fsm_state_type mode = ST_IDLE;
   logic idle_flagged = 1'b0;
   logic [7:0] click_cnt = '0;
   logic [31:0] press_mark = '0;
   logic [31:0] edge_mark = '0;
   logic [31:0] repeat_mark = '0;
   logic level_clean = 1'b0;
   logic level_raw = 1'b0;

   button_click_pattern_detector dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void restart_gesture(input logic [31:0] now);
      mode = ST_IDLE;
      click_cnt = '0;
      press_mark = now;
      idle_flagged = 1'b0;
   endfunction

   function automatic button_report_type predict_gesture(input logic restart, input logic pin,
                                                         input logic [31:0] now);
      logic act;
      logic neg;
      logic [31:0] need;
      logic [31:0] span;
      logic [7:0] ev;
      button_report_type r;
      ev = '0;
      if (restart) begin
         restart_gesture(now);
      end else begin
         act = (pin != knob.active_low);
         neg = knob.debounce_time[15];
         need = neg ? 32'h0001_0000 - {16'h0, knob.debounce_time}
                    : {16'h0, knob.debounce_time};
         // A negative debounce time lets a press through before it is stable.
         if (act && neg) level_clean = 1'b1;
         if (level_raw == act) begin
            if (now - edge_mark >= need) level_clean = act;
         end else begin
            edge_mark = now;
            level_raw = act;
         end
         span = now - press_mark;
         case (mode)
            ST_IDLE: begin
               if (!idle_flagged && span > 32'(knob.idle_time) &&
                   knob.event_enable[EV_IDLE]) begin
                  idle_flagged = 1'b1;
                  ev[EV_IDLE] = 1'b1;
               end
               if (level_clean) begin
                  mode = ST_DOWN;
                  press_mark = now;
                  click_cnt = '0;
                  ev[EV_PRESS] = 1'b1;
               end
            end
            ST_DOWN: begin
               if (!level_clean) begin
                  mode = ST_UP;
                  press_mark = now;
               end else if (span > 32'(knob.long_press_time)) begin
                  ev[EV_LSTART] = 1'b1;
                  mode = ST_LONG;
               end
            end
            ST_UP: begin
               if (click_cnt != COUNT_MAX) click_cnt = click_cnt + 8'd1;
               mode = ST_COUNT;
            end
            ST_COUNT: begin
               if (level_clean) begin
                  mode = ST_DOWN;
                  press_mark = now;
               end else if (span >= 32'(knob.click_gap_time) ||
                            click_cnt == knob.click_limit) begin
                  if (click_cnt == COUNT_SINGLE) ev[EV_CLICK] = 1'b1;
                  else if (click_cnt == COUNT_DOUBLE) ev[EV_DOUBLE] = 1'b1;
                  else ev[EV_MULTI] = 1'b1;
                  restart_gesture(now);
               end
            end
            ST_LONG: begin
               if (!level_clean) begin
                  mode = ST_END;
               end else if (now - repeat_mark >= 32'(knob.repeat_interval)) begin
                  ev[EV_DURING] = 1'b1;
                  repeat_mark = now;
               end
            end
            ST_END: begin
               ev[EV_LSTOP] = 1'b1;
               restart_gesture(now);
            end
            default: mode = ST_IDLE;
         endcase
      end
      r.flags = ev & knob.event_enable;
      r.total = click_cnt;
      r.state = mode;
      r.clean = level_clean;
      r.held = now[15:0] - press_mark[15:0];
      return r;
   endfunction

   function automatic plan_row_type word_row(input logic restart, input logic pin,
                                             input logic [31:0] stamp);
      plan_row_type r;
      r.kind = ROW_WORD;
      r.reg_idx = CSR_DEBOUNCE;
      r.reg_val = '0;
      r.restart = restart;
      r.pin = pin;
      r.stamp = stamp;
      r.golden = 1'b0;
      r.want = '0;
      return r;
   endfunction

   function automatic plan_row_type reg_row(input csr_index_type idx, input logic [15:0] value);
      plan_row_type r;
      r = word_row(1'b0, 1'b0, '0);
      r.kind = ROW_REG;
      r.reg_idx = idx;
      r.reg_val = value;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(input logic restart, input logic pin, input logic [31:0] stamp,
                            input logic has_gold, input button_report_type gold);
      button_report_type guess;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= restart;
      req_tdata <= {7'd0, stamp, pin};
      do @(posedge clock); while (!req_tready);
      guess = predict_gesture(restart, pin, stamp);
      pending_reports.push_back(has_gold ? gold : guess);
      @(negedge clock);
   endtask

   // Stops sending and waits until every predicted report has been matched.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_DEBOUNCE:   knob.debounce_time = value;
         CSR_CLICK_GAP:  knob.click_gap_time = value;
         CSR_LONG_PRESS: knob.long_press_time = value;
         CSR_IDLE_TIME:  knob.idle_time = value;
         CSR_REPEAT:     knob.repeat_interval = value;
         CSR_ACTIVE_LOW: knob.active_low = value[0];
         CSR_CLICK_LIM:  knob.click_limit = value[7:0];
         CSR_EVENT_EN:   knob.event_enable = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Random button gestures: hold and release times are drawn around the thresholds
   // so that clicks, multi clicks, long presses and idle periods all occur.
   task automatic run_gestures(input int words);
      int sent;
      int dur;
      int need;
      int tick_max;
      int step;
      int elapsed;
      int roll;
      int bounce;
      logic pressed;
      sent = 0;
      pressed = 1'b0;
      need = $signed(knob.debounce_time);
      if (need < 0) need = -need;
      tick_max = 1 + (need + int'(knob.click_gap_time) + int'(knob.long_press_time)) / 12;
      while (sent < words) begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            send_word(1'b1, 1'($urandom_range(1)), now_ms, 1'b0, '0);
            sent++;
         end else if (roll < 6) begin
            now_ms = $urandom();
            send_word(1'b0, 1'($urandom_range(1)), now_ms, 1'b0, '0);
            sent++;
         end
         if (pressed)
            dur = need + (($urandom_range(3) == 0)
                  ? int'(knob.long_press_time) + 1 +
                    int'($urandom_range(0, 3 * knob.repeat_interval + 4 * tick_max))
                  : int'($urandom_range(0, knob.long_press_time)));
         else
            dur = need + (($urandom_range(2) == 0)
                  ? int'(knob.click_gap_time) +
                    int'($urandom_range(0, knob.idle_time + 2 * tick_max))
                  : int'($urandom_range(0, knob.click_gap_time / 2)));
         // Contact bounce: a few short samples of the old level at the edge.
         if ($urandom_range(2) == 0) begin
            bounce = $urandom_range(1, 3);
            repeat (bounce) begin
               now_ms += $urandom_range(0, 3);
               send_word(1'b0, !pressed ^ knob.active_low, now_ms, 1'b0, '0);
               sent++;
            end
         end
         elapsed = 0;
         do begin
            step = $urandom_range(1, tick_max);
            now_ms += 32'(step);
            elapsed += step;
            send_word(1'b0, pressed ^ knob.active_low, now_ms, 1'b0, '0);
            sent++;
         end while (elapsed < dur && sent < words);
         pressed = !pressed;
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      button_report_type seen;
      button_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[35:0];
         if (pending_reports.size() == 0) begin
            $error("result word %h arrived with no report pending", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            check_field("event_flags", 16'(want.flags), 16'(seen.flags));
            check_field("click_total", 16'(want.total), 16'(seen.total));
            check_field("machine_state", 16'(want.state), 16'(seen.state));
            check_field("clean_level", 16'(want.clean), 16'(seen.clean));
            check_field("held_time", want.held, seen.held);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("button_click_pattern_detector regression: fail");
         $finish;
      end
   end

   initial begin
      plan_row_type row;
      int dbc, gap, lng, idl, rep, alo, lim, ena;

      // Straight after reset: all events masked, nothing pressed.
      row = word_row(1'b0, 1'b1, 32'h0000_0000);
      row.golden = 1'b1;
      row.want = '{held: 16'd0, clean: 1'b0, state: ST_IDLE, total: 8'd0, flags: 8'd0};
      plan.push_back(row);
      row = word_row(1'b1, 1'b0, 32'hFFFF_FFFF);
      row.golden = 1'b1;
      row.want = '{held: 16'd0, clean: 1'b0, state: ST_IDLE, total: 8'd0, flags: 8'd0};
      plan.push_back(row);
      plan.push_back(reg_row(CSR_EVENT_EN, 16'h00FF));
      plan.push_back(reg_row(CSR_DEBOUNCE, 16'hFFFF));
      plan.push_back(reg_row(CSR_CLICK_LIM, 16'd2));
      // Idle event across the timestamp wrap, then a double click.
      plan.push_back(word_row(1'b0, 1'b1, 32'd2000));
      plan.push_back(word_row(1'b0, 1'b0, 32'd2010));
      plan.push_back(word_row(1'b0, 1'b1, 32'd2100));
      plan.push_back(word_row(1'b0, 1'b1, 32'd2101));
      plan.push_back(word_row(1'b0, 1'b1, 32'd2102));
      plan.push_back(word_row(1'b0, 1'b0, 32'd2150));
      plan.push_back(word_row(1'b0, 1'b1, 32'd2200));
      plan.push_back(word_row(1'b0, 1'b1, 32'd2201));
      plan.push_back(word_row(1'b0, 1'b1, 32'd2202));
      plan.push_back(word_row(1'b0, 1'b1, 32'd2203));
      // Long press with repeats and its release.
      plan.push_back(word_row(1'b0, 1'b0, 32'd5000));
      plan.push_back(word_row(1'b0, 1'b0, 32'd5801));
      plan.push_back(word_row(1'b0, 1'b0, 32'd5802));
      plan.push_back(word_row(1'b0, 1'b1, 32'd6000));
      plan.push_back(word_row(1'b0, 1'b1, 32'd6001));
      plan.push_back(word_row(1'b0, 1'b1, 32'd6002));
      // Soft reset in the middle of a press.
      plan.push_back(word_row(1'b0, 1'b0, 32'd7000));
      plan.push_back(word_row(1'b1, 1'b1, 32'd7010));
      plan.push_back(word_row(1'b0, 1'b0, 32'd7020));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_REG) begin
            settle();
            write_reg(plan[i].reg_idx, plan[i].reg_val);
         end else begin
            send_word(plan[i].restart, plan[i].pin, plan[i].stamp, plan[i].golden,
                      plan[i].want);
         end
      end

      for (int pi = 0; pi < PHASES; pi++) begin
         case (pi)
            0: {dbc, gap, lng, idl, rep, alo, lim, ena} = {32'sd50, 32'd400, 32'd800,
                  32'd1000, 32'd0, 32'd1, 32'd1, 32'hFF};
            1: {dbc, gap, lng, idl, rep, alo, lim, ena} = {-32'sd20, 32'd300, 32'd600,
                  32'd700, 32'd50, 32'd0, 32'd2, 32'h7F};
            2: {dbc, gap, lng, idl, rep, alo, lim, ena} = {32'sd0, 32'd0, 32'd0,
                  32'd0, 32'd0, 32'd1, 32'd255, 32'h00};
            3: {dbc, gap, lng, idl, rep, alo, lim, ena} = {-32'sd32768, 32'd65535, 32'd65535,
                  32'd65535, 32'd65535, 32'd0, 32'd3, 32'hAA};
            4: {dbc, gap, lng, idl, rep, alo, lim, ena} = {32'sd32767, 32'd1000, 32'd2000,
                  32'd3000, 32'd100, 32'd1, 32'd100, 32'h55};
            default: begin
               dbc = int'($urandom_range(0, 400)) - 200;
               gap = $urandom_range(0, 2000);
               lng = $urandom_range(0, 3000);
               idl = $urandom_range(0, 3000);
               rep = $urandom_range(0, 300);
               alo = $urandom_range(1);
               lim = ($urandom_range(1) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 255);
               ena = $urandom_range(255);
            end
         endcase
         settle();
         write_reg(CSR_DEBOUNCE, 16'(dbc));
         write_reg(CSR_CLICK_GAP, 16'(gap));
         write_reg(CSR_LONG_PRESS, 16'(lng));
         write_reg(CSR_IDLE_TIME, 16'(idl));
         write_reg(CSR_REPEAT, 16'(rep));
         write_reg(CSR_ACTIVE_LOW, 16'(alo));
         write_reg(CSR_CLICK_LIM, 16'(lim));
         write_reg(CSR_EVENT_EN, 16'(ena));
         case (pi % 4)
            0: {send_idle_pct, stall_pct} = {32'd0, 32'd0};
            1: {send_idle_pct, stall_pct} = {32'd74, 32'd0};
            2: {send_idle_pct, stall_pct} = {32'd0, 32'd74};
            default: {send_idle_pct, stall_pct} = {32'd6, 32'd6};
         endcase
         // Odd phases start just short of the timestamp wrap.
         now_ms = pi[0] ? 32'hFFFF_F000 : $urandom();
         run_gestures(PHASE_WORDS);
      end

      settle();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_reports.size() == 0) begin
         $display("button_click_pattern_detector regression: pass");
      end else begin
         $display("button_click_pattern_detector regression: fail");
      end
      $finish;
   end

endmodule
